@@ rtl/core/dpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpfc_pkg
// Shared types and constants for the distinct prime factor counter:
// controller commands, datapath status and fixed result width.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfc_pkg;

  // result width, fixed by the output field
  localparam int COUNT_WIDTH = 4;

  // first trial divisor; after it the divisor steps over even numbers
  localparam int FIRST_DIVISOR = 2;

  // controller to datapath
  typedef struct packed {
    logic load;       // take a new request, reset divisor and count
    logic div_start;  // start a division of remainder by trial divisor
    logic take_quot;  // remainder <= quotient
    logic inc_count;  // one more distinct prime found
    logic next_div;   // advance to the next trial divisor
    logic load_out;   // capture final count into the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_le1;      // remainder is 0 or 1
    logic div_done;     // division finished this cycle
    logic quot_lt_div;  // quotient below divisor: divisor squared exceeds remainder
    logic mod_zero;     // divisor divides remainder
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/dpfc_divider.sv @@
// ----------------------------------------------------------------------------
// dpfc_divider
// Restoring divider, one quotient bit per cycle. A start pulse latches the
// operands; done pulses for one cycle after VALUE_WIDTH steps and the
// quotient and modulus hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfc_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [VALUE_WIDTH-1:0]     dividend,
  input  wire logic [VALUE_WIDTH/2:0]     divisor,
  output logic      [VALUE_WIDTH-1:0]     quotient,
  output logic      [VALUE_WIDTH/2:0]     modulus,
  output logic                            done
);

  localparam int DW = VALUE_WIDTH / 2 + 1;
  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] dvd;
  logic [DW-1:0]          dvs;
  logic [DW-1:0]          part;
  logic [CW-1:0]          steps;
  logic                   busy;

  logic [DW:0]            trial;
  logic                   fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {part, dvd[VALUE_WIDTH-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      part  <= '0;
      steps <= CW'(VALUE_WIDTH - 1);
    end else if (busy) begin
      part  <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      dvd   <= {dvd[VALUE_WIDTH-2:0], fits};
      steps <= steps - CW'(1);
    end
  end

  assign quotient = dvd;
  assign modulus  = part;

endmodule

`default_nettype wire

@@ rtl/core/dpfc_datapath.sv @@
// ----------------------------------------------------------------------------
// dpfc_datapath
// Remainder, trial divisor and count registers around the shared divider,
// plus the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfc_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [VALUE_WIDTH-1:0]             value,
  input  wire dpfc_pkg::cmd_t                     cmd,
  output dpfc_pkg::sts_t                          sts,
  output logic      [dpfc_pkg::COUNT_WIDTH-1:0]   prime_count
);

  localparam int DW = VALUE_WIDTH / 2 + 1;
  localparam int NW = dpfc_pkg::COUNT_WIDTH;

  logic [VALUE_WIDTH-1:0] remainder;
  logic [DW-1:0]          trial_divisor;
  logic [NW-1:0]          found_count;

  logic [VALUE_WIDTH-1:0] quot;
  logic [DW-1:0]          modv;
  logic                   div_done;
  logic                   rem_gt1;

  dpfc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (remainder),
    .divisor  (trial_divisor),
    .quotient (quot),
    .modulus  (modv),
    .done     (div_done)
  );

  assign rem_gt1 = (remainder[VALUE_WIDTH-1:1] != '0);

  always_comb begin
    sts.rem_le1     = !rem_gt1;
    sts.div_done    = div_done;
    sts.quot_lt_div = (quot < VALUE_WIDTH'(trial_divisor));
    sts.mod_zero    = (modv == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remainder     <= value;
      trial_divisor <= DW'(dpfc_pkg::FIRST_DIVISOR);
      found_count   <= '0;
    end else begin
      if (cmd.take_quot) begin
        remainder <= quot;
      end
      if (cmd.inc_count) begin
        found_count <= found_count + NW'(1);
      end
      if (cmd.next_div) begin
        // 2 -> 3, then odd numbers only
        trial_divisor <= (trial_divisor == DW'(dpfc_pkg::FIRST_DIVISOR))
                         ? trial_divisor + DW'(1) : trial_divisor + DW'(2);
      end
    end
    // a leftover above one is one more prime
    if (cmd.load_out) begin
      prime_count <= found_count + NW'(rem_gt1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dpfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpfc_ctrl
// Controller: sequences trial divisions, the strip-out of each divisor
// found, and the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dpfc_pkg::cmd_t       cmd,
  input  wire dpfc_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE_TEST,
    ST_WAIT_TEST,
    ST_ISSUE_STRIP,
    ST_WAIT_STRIP,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = sts.rem_le1 ? ST_DONE : ST_ISSUE_TEST;
      end
      ST_ISSUE_TEST: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_TEST;
      end
      ST_WAIT_TEST: begin
        if (sts.div_done) begin
          if (sts.quot_lt_div) begin
            state_next = ST_DONE;
          end else if (sts.mod_zero) begin
            cmd.inc_count = 1'b1;
            cmd.take_quot = 1'b1;
            state_next    = ST_ISSUE_STRIP;
          end else begin
            cmd.next_div = 1'b1;
            state_next   = ST_ISSUE_TEST;
          end
        end
      end
      ST_ISSUE_STRIP: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_STRIP;
      end
      ST_WAIT_STRIP: begin
        if (sts.div_done) begin
          if (sts.mod_zero) begin
            cmd.take_quot = 1'b1;
            state_next    = ST_ISSUE_STRIP;
          end else begin
            cmd.next_div = 1'b1;
            state_next   = ST_ISSUE_TEST;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/distinct_prime_factor_counter.sv @@
// ----------------------------------------------------------------------------
// distinct_prime_factor_counter
// Counts the distinct primes dividing an unsigned number by trial division.
// Each divisor found is divided out completely and counted once; the search
// stops once the divisor squared exceeds what is left.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   input     in_valid / in_stall    value       [VALUE_WIDTH-1:0] unsigned
//   output    out_valid / out_stall  prime_count [3:0]             unsigned
//
// division: each trial division runs on the shared one-bit-per-cycle divider
//   (issue, VALUE_WIDTH steps, decision); there is one per trial divisor up
//   to sqrt(value) and one per strip-out of a found prime; worst near 2^15
//   divisors at the default width; 0 and 1 skip all divisions, and the next
//   request is taken once the controller is back in idle
// reset: rst is synchronous, returns the controller to idle, no result held
// stalls: one request at a time; in_stall is high from acceptance until the
//   result is written into the output register, which holds under out_stall
//
`default_nettype none

module distinct_prime_factor_counter #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [VALUE_WIDTH-1:0]             value,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [dpfc_pkg::COUNT_WIDTH-1:0]   prime_count
);

  dpfc_pkg::cmd_t cmd;
  dpfc_pkg::sts_t sts;

  // sequencing of divisions and both handshakes
  dpfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // remainder, divisor, count, divider and result register
  dpfc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .sts         (sts),
    .prime_count (prime_count)
  );

endmodule

`default_nettype wire
